// ===== src/b7cc_pkg.sv =====
package b7cc_pkg;

    // Port field widths
    localparam int unsigned STREAM_WORD_W = 32;
    localparam int unsigned DECODED_W     = 32;

    // Default sizes of the decode datapath
    localparam int unsigned WORD_BITS_DEF  = 32;
    localparam int unsigned VALUE_BITS_DEF = 32;

    // Digit groups
    localparam int unsigned   GROUP_W    = 3;
    localparam logic [2:0]    TERM_GROUP = 3'd7;

endpackage

// ===== src/b7cc_in_if.sv =====
interface b7cc_in_if;

    logic                                    valid;
    logic                                    ready;
    logic [b7cc_pkg::STREAM_WORD_W-1:0]      stream_word;
    logic                                    stream_start;

    modport source (output valid, output stream_word, output stream_start, input ready);
    modport sink   (input valid, input stream_word, input stream_start, output ready);

endinterface

// ===== src/b7cc_out_if.sv =====
interface b7cc_out_if;

    logic                                valid;
    logic                                ready;
    logic [b7cc_pkg::DECODED_W-1:0]      decoded_value;
    logic                                last_of_word;

    modport source (output valid, output decoded_value, output last_of_word, input ready);
    modport sink   (input valid, input decoded_value, input last_of_word, output ready);

endinterface

// ===== src/base7_comma_code_decoder.sv =====
// Base-7 comma code decoder. Each accepted beat on the stream channel carries
// one word of packed 3-bit groups, read least significant bit first after up to
// two bits left over from the previous word. Groups 0..6 extend the running
// value (value*7 + group + 1, wrapping at VALUE_BITS); group 7 sends the value
// as one result beat and clears it, with last_of_word set on the final result
// of the word. stream_start clears the leftover bits and the running value.
// One shared shift-subtract-add unit handles one group per cycle while the
// result register has room; a terminator group waits for it to drain. After
// the groups the block stores the leftover bits, then returns to idle with
// ready high. The block takes no new word until the current one is finished.
module base7_comma_code_decoder #(
    parameter int unsigned WORD_BITS  = b7cc_pkg::WORD_BITS_DEF,
    parameter int unsigned VALUE_BITS = b7cc_pkg::VALUE_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    b7cc_in_if.sink           stream,
    b7cc_out_if.source        result
);

    // Group counts and leftover counts for each possible carried-in bit count
    localparam int unsigned GMAX  = (WORD_BITS + 2) / 3;
    localparam int unsigned SBITS = 3 * ((WORD_BITS + 4) / 3);
    localparam int unsigned GW    = $clog2(GMAX + 1);
    localparam int unsigned GC0   = WORD_BITS / 3;
    localparam int unsigned GC1   = (WORD_BITS + 1) / 3;
    localparam int unsigned GC2   = (WORD_BITS + 2) / 3;
    localparam int unsigned RC0   = WORD_BITS % 3;
    localparam int unsigned RC1   = (WORD_BITS + 1) % 3;
    localparam int unsigned RC2   = (WORD_BITS + 2) % 3;

    localparam int unsigned DECODED_W_L = b7cc_pkg::DECODED_W;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t                  state_reg, state_next;
    logic [SBITS-1:0]        shift_reg, shift_next;
    logic [GMAX-1:0]         term_reg, term_next;
    logic [GW-1:0]           left_reg, left_next;
    logic [VALUE_BITS-1:0]   partial_reg, partial_next;
    logic [1:0]              lcnt_reg, lcnt_next;
    logic [1:0]              lbits_reg, lbits_next;
    logic                    out_valid_reg, out_valid_next;
    logic [DECODED_W_L-1:0]  out_value_reg, out_value_next;
    logic                    out_last_reg, out_last_next;

    // Accept-side datapath
    logic [WORD_BITS+b7cc_pkg::STREAM_WORD_W-1:0] word_ext;
    logic [WORD_BITS-1:0]    word;
    logic [1:0]              cnt_eff;
    logic [1:0]              lbits_eff;
    logic [SBITS-1:0]        stream_c;
    logic [GW-1:0]           groups_c;
    logic [1:0]              rem_c;
    logic [GMAX-1:0]         term_c;

    // Shared step unit
    logic [2:0]              grp;
    logic                    is_term;
    logic                    out_free;
    logic [VALUE_BITS-1:0]   partial_step;
    logic [VALUE_BITS+DECODED_W_L-1:0] value_ext;
    logic                    accept;

    assign accept   = stream.valid && stream.ready;
    assign out_free = !out_valid_reg || result.ready;

    // Fit the port word to the decode word width
    assign word_ext  = {{WORD_BITS{1'b0}}, stream.stream_word};
    assign word      = word_ext[WORD_BITS-1:0];
    assign cnt_eff   = stream.stream_start ? 2'd0 : lcnt_reg;
    assign lbits_eff = stream.stream_start ? 2'd0 : lbits_reg;

    // Join leftover bits ahead of the new word
    assign stream_c = (SBITS'(word) << cnt_eff) | SBITS'(lbits_eff);

    // Count groups and leftover bits for this word
    always_comb
    begin
        unique case (cnt_eff)
            2'd0:
            begin
                groups_c = GW'(GC0);
                rem_c    = 2'(RC0);
            end
            2'd1:
            begin
                groups_c = GW'(GC1);
                rem_c    = 2'(RC1);
            end
            default:
            begin
                groups_c = GW'(GC2);
                rem_c    = 2'(RC2);
            end
        endcase
    end

    // Mark terminator groups of the word
    always_comb
    begin
        for (int g = 0; g < GMAX; g++)
        begin
            term_c[g] = (stream_c[3*g +: 3] == b7cc_pkg::TERM_GROUP) && (GW'(g) < groups_c);
        end
    end

    // Multiply by seven as a shift and subtract, then add the digit
    assign grp          = shift_reg[2:0];
    assign is_term      = (grp == b7cc_pkg::TERM_GROUP);
    assign partial_step = (partial_reg << 3) - partial_reg
                          + VALUE_BITS'(grp) + VALUE_BITS'(1);
    assign value_ext    = {{DECODED_W_L{1'b0}}, partial_reg};

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        shift_next     = shift_reg;
        term_next      = term_reg;
        left_next      = left_reg;
        partial_next   = partial_reg;
        lcnt_next      = lcnt_reg;
        lbits_next     = lbits_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    shift_next   = stream_c;
                    term_next    = term_c;
                    left_next    = groups_c;
                    lcnt_next    = rem_c;
                    if (stream.stream_start)
                    begin
                        partial_next = '0;
                    end
                    state_next   = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (left_reg == '0)
                begin
                    // Keep the unread tail for the next word
                    lbits_next = shift_reg[1:0] & {lcnt_reg == 2'd2, lcnt_reg != 2'd0};
                    state_next = ST_IDLE;
                end
                else if (is_term)
                begin
                    // Send the value once the result register has room
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_value_next = value_ext[DECODED_W_L-1:0];
                        out_last_next  = (term_reg[GMAX-1:1] == '0);
                        partial_next   = '0;
                        shift_next     = shift_reg >> 3;
                        term_next      = term_reg >> 1;
                        left_next      = left_reg - GW'(1);
                    end
                end
                else
                begin
                    partial_next = partial_step;
                    shift_next   = shift_reg >> 3;
                    term_next    = term_reg >> 1;
                    left_next    = left_reg - GW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            left_reg      <= '0;
            partial_reg   <= '0;
            lcnt_reg      <= '0;
            lbits_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            left_reg      <= left_next;
            partial_reg   <= partial_next;
            lcnt_reg      <= lcnt_next;
            lbits_reg     <= lbits_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        shift_reg     <= shift_next;
        term_reg      <= term_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    assign stream.ready         = (state_reg == ST_IDLE);
    assign result.valid         = out_valid_reg;
    assign result.decoded_value = out_value_reg;
    assign result.last_of_word  = out_last_reg;

endmodule
